// ----- design/weighted_center_of_mass_split_top_assert.svh -----
// assertion macros shared by the mass centroid rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef WEIGHTED_CENTER_OF_MASS_SPLIT_TOP_ASSERT_SVH
`define WEIGHTED_CENTER_OF_MASS_SPLIT_TOP_ASSERT_SVH

// same-cycle implication
`define WCM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wcm assertion failed");

// next-cycle implication
`define WCM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wcm assertion failed");

`endif

// ----- design/wcm_pkg.sv -----
// types and constants of the mass weighted centroid block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package wcm_pkg;

    localparam int POS_W         = 20;
    localparam int RAD_W         = 12;
    localparam int TIME_W        = 32;
    localparam int MAX_PARTICLES = 256;
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

    localparam int NGRP  = 3;
    localparam int NAXIS = 3;
    localparam int NSUM  = NGRP * NAXIS;
    localparam int IDX_W = $clog2(NSUM);
    localparam int GRP_W = $clog2(NGRP);
    localparam int AX_W  = $clog2(NAXIS);

    localparam int GRP_ALL   = 0;
    localparam int GRP_SMALL = 1;
    localparam int GRP_LARGE = 2;

    localparam int SQ_W   = 2 * RAD_W;
    localparam int MASS_W = 3 * RAD_W;
    localparam int PROD_W = MASS_W + 1 + POS_W;
    localparam int WSUM_W = 64;
    localparam int MSUM_W = 44;

    // quotient magnitude never exceeds the position range
    localparam int Q_W    = POS_W;
    localparam int QCNT_W = $clog2(Q_W);
    localparam int REM_W  = WSUM_W - Q_W;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic        [RAD_W-1:0]  radius;
        logic        [TIME_W-1:0] frame_time;
        logic                     frame_last;
    } t_in_item;

    typedef struct packed {
        logic        [TIME_W-1:0] out_time;
        logic signed [POS_W-1:0]  all_x;
        logic signed [POS_W-1:0]  all_y;
        logic signed [POS_W-1:0]  all_z;
        logic signed [POS_W-1:0]  small_x;
        logic signed [POS_W-1:0]  small_y;
        logic signed [POS_W-1:0]  small_z;
        logic signed [POS_W-1:0]  large_x;
        logic signed [POS_W-1:0]  large_y;
        logic signed [POS_W-1:0]  large_z;
        logic        [NGRP-1:0]   empty_groups;
        logic                     overflow;
    } t_out_item;

    // one finished frame handed from the front to the back
    typedef struct packed {
        logic [NSUM-1:0][WSUM_W-1:0] wsum;
        logic [NGRP-1:0][MSUM_W-1:0] msum;
        logic [TIME_W-1:0]           frame_time;
        logic                        over;
    } t_frame;

    typedef struct packed {
        logic              start;
        logic [WSUM_W-1:0] num;
        logic [MSUM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- design/wcm_front.sv -----
// front part: takes particles, computes mass, accumulates the frame sums
// depends on wcm_pkg; pushes each finished frame into the frame queue
`timescale 1ns / 1ps
`default_nettype none

module wcm_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [wcm_pkg::RAD_W-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  wcm_pkg::t_in_item       i_in_data,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output wcm_pkg::t_frame         o_q_data
);
    import wcm_pkg::*;

    typedef struct packed {
        logic              take;
        logic              small_grp;
        logic              large_grp;
        logic              last;
        logic              over;
        logic [TIME_W-1:0] ftime;
    } t_tag;

    logic [RAD_W-1:0] r_split;
    logic [CNT_W-1:0] r_cnt;
    logic             r_over;

    logic r_v1, r_v2, r_v3, r_v4;
    t_tag r_tag1, r_tag2, r_tag3, r_tag4;
    logic [NAXIS-1:0][POS_W-1:0] r_pos1, r_pos2, r_pos3;
    logic [RAD_W-1:0]  r_rad1, r_rad2;
    logic [SQ_W-1:0]   r_sq2;
    logic [MASS_W-1:0] r_mass3, r_mass4;
    logic [NAXIS-1:0][PROD_W-1:0] r_prod4;

    logic [NSUM-1:0][WSUM_W-1:0] r_wsum, n_wsum;
    logic [NGRP-1:0][MSUM_W-1:0] r_msum, n_msum;

    logic                     w_adv;
    logic                     w_acc;
    logic                     w_cnt_full;
    logic                     w_split_on;
    logic                     w_below;
    t_tag                     n_tag1;
    logic [NGRP-1:0]          w_en;
    logic signed [PROD_W-1:0] w_prod [NAXIS];

    // the whole pipe holds only while a frame end waits for queue space
    assign w_adv      = !(r_v4 && r_tag4.last && i_q_full);
    assign o_in_ready = w_adv;
    assign w_acc      = i_in_valid && w_adv;

    assign w_cnt_full = (r_cnt >= CNT_W'(MAX_PARTICLES));
    assign w_split_on = (r_split != '0);
    assign w_below    = (i_in_data.radius < r_split);

    always_comb begin
        n_tag1.take      = !w_cnt_full;
        n_tag1.small_grp = w_split_on && w_below;
        n_tag1.large_grp = w_split_on && !w_below;
        n_tag1.last      = i_in_data.frame_last;
        n_tag1.over      = r_over || w_cnt_full;
        n_tag1.ftime     = i_in_data.frame_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= '0;
        end else if (i_cfg_we) begin
            r_split <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_over <= 1'b0;
        end else if (w_acc) begin
            if (i_in_data.frame_last) begin
                r_cnt  <= '0;
                r_over <= 1'b0;
            end else if (w_cnt_full) begin
                r_over <= 1'b1;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        for (int a = 0; a < NAXIS; a++) begin
            w_prod[a] = $signed({1'b0, r_mass3}) * $signed(r_pos3[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag1    <= n_tag1;
            r_pos1[0] <= i_in_data.pos_x;
            r_pos1[1] <= i_in_data.pos_y;
            r_pos1[2] <= i_in_data.pos_z;
            r_rad1    <= i_in_data.radius;

            r_tag2 <= r_tag1;
            r_pos2 <= r_pos1;
            r_rad2 <= r_rad1;
            r_sq2  <= SQ_W'(r_rad1) * SQ_W'(r_rad1);

            r_tag3  <= r_tag2;
            r_pos3  <= r_pos2;
            r_mass3 <= MASS_W'(r_sq2) * MASS_W'(r_rad2);

            r_tag4  <= r_tag3;
            r_mass4 <= r_mass3;
            for (int a = 0; a < NAXIS; a++) begin
                r_prod4[a] <= w_prod[a];
            end
        end
    end

    // lane enables: total for every taken particle, small or large only with the split on
    assign w_en[GRP_ALL]   = r_tag4.take;
    assign w_en[GRP_SMALL] = r_tag4.take && r_tag4.small_grp;
    assign w_en[GRP_LARGE] = r_tag4.take && r_tag4.large_grp;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            for (int a = 0; a < NAXIS; a++) begin
                n_wsum[g*NAXIS+a] = r_wsum[g*NAXIS+a] +
                    (w_en[g] ? {{(WSUM_W-PROD_W){r_prod4[a][PROD_W-1]}}, r_prod4[a]}
                             : {WSUM_W{1'b0}});
            end
            n_msum[g] = r_msum[g] + (w_en[g] ? MSUM_W'(r_mass4) : {MSUM_W{1'b0}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
            r_msum <= '0;
        end else if (w_adv && r_v4) begin
            if (r_tag4.last) begin
                r_wsum <= '0;
                r_msum <= '0;
            end else begin
                r_wsum <= n_wsum;
                r_msum <= n_msum;
            end
        end
    end

    assign o_q_push            = r_v4 && r_tag4.last && w_adv;
    assign o_q_data.wsum       = n_wsum;
    assign o_q_data.msum       = n_msum;
    assign o_q_data.frame_time = r_tag4.ftime;
    assign o_q_data.over       = r_tag4.over;

endmodule

`default_nettype wire

// ----- design/wcm_fifo.sv -----
// short queue of finished frames between the front and the back
// depends on wcm_pkg for the frame record type and depth
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_center_of_mass_split_top_assert.svh"

module wcm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wcm_pkg::t_frame i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output wcm_pkg::t_frame o_head
);
    import wcm_pkg::*;

    t_frame             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : r_rp + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
            end
        end
    end

    `WCM_ASSERT_IMP(a_push_not_full, i_push, !o_full)
    `WCM_ASSERT_IMP(a_pop_not_empty, i_pop, !o_empty)

endmodule

`default_nettype wire

// ----- design/wcm_div.sv -----
// signed by unsigned restoring divider, one quotient bit per cycle
// depends on wcm_pkg; quotient truncates toward zero
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_center_of_mass_split_top_assert.svh"

module wcm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wcm_pkg::t_div_req i_req,
    output wcm_pkg::t_div_rsp o_rsp
);
    import wcm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic              r_neg;
    logic [REM_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_low;
    logic [Q_W-1:0]    r_quo;
    logic [MSUM_W-1:0] r_den;

    logic [WSUM_W-1:0] w_mag;
    logic [REM_W:0]    w_trial;
    logic [REM_W:0]    w_diff;
    logic              w_ge;

    assign w_mag = i_req.num[WSUM_W-1] ? (~i_req.num + WSUM_W'(1)) : i_req.num;

    // remainder stays below the divisor, so only the top trial bit can spill
    assign w_trial = {r_rem, r_low[Q_W-1]};
    assign w_ge    = (w_trial >= (REM_W+1)'(r_den));
    assign w_diff  = w_trial - (REM_W+1)'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == QCNT_W'(Q_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + QCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.num[WSUM_W-1];
            r_rem <= w_mag[WSUM_W-1:Q_W];
            r_low <= w_mag[Q_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            r_low <= {r_low[Q_W-2:0], 1'b0};
            r_quo <= {r_quo[Q_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (~r_quo + Q_W'(1)) : r_quo;

    `WCM_ASSERT_IMP(a_start_when_idle, i_req.start, !r_busy)
    `WCM_ASSERT_NXT(a_busy_after_start, i_req.start, r_busy)

endmodule

`default_nettype wire

// ----- design/wcm_back.sv -----
// back part: divides the nine sums of the head frame (zero for an empty group) and emits the result
// depends on wcm_pkg and wcm_div; holds the output register
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_center_of_mass_split_top_assert.svh"

module wcm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  wcm_pkg::t_frame    i_q_head,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wcm_pkg::t_out_item o_out_data
);
    import wcm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [GRP_W-1:0] r_grp, n_grp;
    logic [AX_W-1:0]  r_ax, n_ax;
    logic [NSUM-1:0][POS_W-1:0] r_res;
    logic             r_out_vld;
    t_out_item        r_out, n_out;

    t_div_req          w_req;
    t_div_rsp          w_rsp;
    logic [MSUM_W-1:0] w_den;
    logic              w_den_zero;
    logic              w_step;
    logic              w_res_we;
    logic [POS_W-1:0]  w_res_val;
    logic              w_out_free;
    logic              w_pop;
    logic [NGRP-1:0]   w_empty;

    assign w_den      = i_q_head.msum[r_grp];
    assign w_den_zero = (w_den == '0);
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_pop      = (r_state == ST_EMIT) && w_out_free;
    assign o_q_pop    = w_pop;

    assign w_req.start = (r_state == ST_START) && !w_den_zero;
    assign w_req.num   = i_q_head.wsum[r_idx];
    assign w_req.den   = w_den;

    wcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_grp     = r_grp;
        n_ax      = r_ax;
        w_step    = 1'b0;
        w_res_we  = 1'b0;
        w_res_val = w_rsp.quo;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_START;
                    n_idx   = '0;
                    n_grp   = '0;
                    n_ax    = '0;
                end
            end
            ST_START: begin
                // an empty group yields zero without a division
                if (w_den_zero) begin
                    w_step    = 1'b1;
                    w_res_we  = 1'b1;
                    w_res_val = '0;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_rsp.done) begin
                    w_step   = 1'b1;
                    w_res_we = 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_step) begin
            if (r_idx == IDX_W'(NSUM-1)) begin
                n_state = ST_EMIT;
            end else begin
                n_state = ST_START;
                n_idx   = r_idx + IDX_W'(1);
                if (r_ax == AX_W'(NAXIS-1)) begin
                    n_ax  = '0;
                    n_grp = r_grp + GRP_W'(1);
                end else begin
                    n_ax = r_ax + AX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_grp   <= '0;
            r_ax    <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_grp   <= n_grp;
            r_ax    <= n_ax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            r_res[r_idx] <= w_res_val;
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_empty[g] = (i_q_head.msum[g] == '0);
        end
        n_out.out_time     = i_q_head.frame_time;
        n_out.all_x        = r_res[GRP_ALL*NAXIS+0];
        n_out.all_y        = r_res[GRP_ALL*NAXIS+1];
        n_out.all_z        = r_res[GRP_ALL*NAXIS+2];
        n_out.small_x      = r_res[GRP_SMALL*NAXIS+0];
        n_out.small_y      = r_res[GRP_SMALL*NAXIS+1];
        n_out.small_z      = r_res[GRP_SMALL*NAXIS+2];
        n_out.large_x      = r_res[GRP_LARGE*NAXIS+0];
        n_out.large_y      = r_res[GRP_LARGE*NAXIS+1];
        n_out.large_z      = r_res[GRP_LARGE*NAXIS+2];
        n_out.empty_groups = w_empty;
        n_out.overflow     = i_q_head.over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_pop) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `WCM_ASSERT_IMP(a_div_only_in_wait, w_rsp.busy || w_rsp.done, r_state == ST_WAIT)
    `WCM_ASSERT_NXT(a_pop_loads_output, w_pop, r_out_vld)

endmodule

`default_nettype wire

// ----- design/weighted_center_of_mass_split_top.sv -----
// Mass weighted centroid of a particle frame with an optional small/large split by radius.
// Particles are taken one per cycle unless the input stalls: a four stage front computes the
// mass (radius cubed) and the mass times position products and adds them into the total, small
// and large sums. The last particle of a frame hands the sums to a two-frame queue. The back
// works on the queue head with one shared restoring divider that produces one quotient bit per
// cycle: each of the nine centroid values is divided in turn (a group with zero mass gives zero
// without a division), so the divider sets how short frames may be at full input rate. The
// input stalls only when a frame ends while the queue already holds the head frame and one more
// behind it. Beyond 256 particles in a frame the extra particles are dropped and overflow is
// reported.
// Depends on wcm_pkg, wcm_front, wcm_fifo and wcm_back.
`timescale 1ns / 1ps
`default_nettype none

module weighted_center_of_mass_split_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wcm_pkg::RAD_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  wcm_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output wcm_pkg::t_out_item        o_out_data
);
    import wcm_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    t_frame w_wdata;
    t_frame w_head;

    wcm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_data   (w_wdata)
    );

    wcm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdata),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    wcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_q_head    (w_head),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
